// ----- rtl/bsb_pkg.sv -----
// package for the b-spline basis evaluator: widths, constants, types
// no dependencies
`default_nettype none
package bsb_pkg;
    localparam int MAX_KNOTS  = 64;
    localparam int MAX_DEGREE = 7;
    localparam int FRAC_BITS  = 16;
    localparam int VW = FRAC_BITS + 1;
    localparam int AW = $clog2(MAX_KNOTS);
    localparam int DW = 3;
    localparam logic [VW-1:0] ONE_FX = VW'(1) << FRAC_BITS;
    localparam logic [DW-1:0] DEGREE_RESET = 3'd3;
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_EVAL  = 1'b1;
    localparam logic [0:0] REG_DEGREE = 1'b0;

    typedef enum logic [3:0] {
        S_IDLE, S_LEAF_RD, S_LEAF_T0, S_LEAF, S_NODE_RD0, S_NODE_RD1, S_NODE_RD2,
        S_NODE_RD3, S_NODE_CHK, S_DIV_A, S_WAIT_A, S_DIV_B, S_WAIT_B, S_MUL_A, S_MUL_B,
        S_OUT
    } t_state;

    function automatic logic [VW-1:0] sat_one(input logic [VW:0] x);
        sat_one = (x > {1'b0, ONE_FX}) ? ONE_FX : x[VW-1:0];
    endfunction
endpackage
`default_nettype wire

// ----- rtl/bsb_ram.sv -----
// generic single-port-write, single-read ram with registered read
// no dependencies
`default_nettype none
module bsb_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- rtl/bsb_div.sv -----
// restoring divider, one quotient bit per cycle: floor((num << FRAC_BITS) / den), capped at one
// depends on bsb_pkg
`default_nettype none
module bsb_div
    import bsb_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [VW-1:0] i_num,
    input  wire logic [VW-1:0] i_den,
    output      logic          o_done,
    output      logic [VW-1:0] o_quot
);
    localparam int NW = VW + FRAC_BITS;
    localparam int CW = $clog2(NW + 1);
    logic [NW-1:0] r_num, n_num;
    logic [NW-1:0] r_quot, n_quot;
    logic [VW-1:0] r_rem, n_rem;
    logic [VW-1:0] r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic [VW:0]   w_sh;

    always_comb begin
        w_sh   = {r_rem, r_num[NW-1]};
        n_num  = r_num << 1;
        n_rem  = w_sh[VW-1:0];
        n_quot = r_quot << 1;
        if (w_sh >= {1'b0, r_den}) begin
            n_rem  = VW'(w_sh - {1'b0, r_den});
            n_quot = n_quot | NW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
                r_num  <= {i_num, FRAC_BITS'(0)};
                r_den  <= i_den;
                r_rem  <= '0;
                r_quot <= '0;
            end else if (r_busy) begin
                r_num  <= n_num;
                r_rem  <= n_rem;
                r_quot <= n_quot;
                r_cnt  <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_quot = (r_quot > NW'(ONE_FX)) ? ONE_FX : r_quot[VW-1:0];
endmodule
`default_nettype wire

// ----- rtl/bspline_basis_eval.sv -----
// b-spline basis evaluator, cox-de boor triangle over a knot table in ram
// depends on bsb_pkg, bsb_ram, bsb_div
//
// channel  dir  handshake        payload
// s_axis   in   tvalid/tready    tdata, tuser=req_type
// m_axis   out  tvalid/tready    tdata, tuser=index_error
// apb      in   psel/penable     degree at address 0 (decoded from paddr[2], so 0 to 3)
//
// a knot write is taken in any idle cycle. an evaluate reads the leaves, then works
// each node with four ram reads; a node whose span holds u then takes up to two
// divisions on one shared divider and two multiply steps, and any other is zero.
// the result then moves into the output register; an index error skips the leaves
// and nodes. reset is synchronous and clears control and degree (3).
// a waiting result sits in the output register; a finished evaluate stalls only
// while that register is full and not being taken.
`default_nettype none
module bspline_basis_eval
    import bsb_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output      logic         s_axis_tready,
    input  wire logic [47:0]  s_axis_tdata,  // knot_index, knot_value, param_u, basis_index
    input  wire logic         s_axis_tuser,  // req_type
    output      logic         m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output      logic [23:0]  m_axis_tdata,  // basis_value, zero fill
    output      logic         m_axis_tuser,  // index_error
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output      logic [31:0]  prdata,
    output      logic         pready
);
    t_state r_state, n_state;
    logic [DW-1:0] r_degree, n_degree, r_d, n_d, r_j, n_j;
    logic [AW-1:0] r_i, n_i;
    logic [VW-1:0] r_u, n_u, r_t0, n_t0, r_t1, n_t1, r_td, n_td, r_te, n_te;
    logic [VW-1:0] r_wa, n_wa, r_wb, n_wb, r_acc, n_acc, r_res, n_res;
    logic          r_err, n_err;
    logic [VW-1:0] r_node [MAX_DEGREE+1];
    logic [VW-1:0] r_out, n_out;
    logic          r_oerr, n_oerr, r_ovalid, n_ovalid;
    logic          node_we, node_done;
    logic [VW-1:0] node_val;
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [VW-1:0] ram_wdata, ram_rdata;
    logic          div_start, div_done;
    logic [VW-1:0] div_num, div_den, div_q;
    logic [VW-1:0] mul_a, mul_b;
    logic [2*VW-1:0] prod;
    logic [VW:0]   sum;
    logic [AW-1:0] base;
    logic [AW+1:0] lim;

    assign pready = 1'b1;
    assign prdata = {{(32-DW){1'b0}}, r_degree};
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {7'd0, r_out};
    assign m_axis_tuser  = r_oerr;

    bsb_ram #(.WIDTH(VW), .DEPTH(MAX_KNOTS)) u_ram (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(ram_waddr), .i_wdata(ram_wdata),
        .i_raddr(ram_raddr), .o_rdata(ram_rdata));

    bsb_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start), .i_num(div_num),
        .i_den(div_den), .o_done(div_done), .o_quot(div_q));

    // knot write straight from the request
    assign ram_we    = s_axis_tvalid && s_axis_tready && (s_axis_tuser == REQ_WRITE);
    assign ram_waddr = s_axis_tdata[5:0];
    assign ram_wdata = sat_one({1'b0, s_axis_tdata[22:6]});

    assign base = r_i + {{(AW-DW){1'b0}}, r_j};
    assign lim  = {2'b0, s_axis_tdata[45:40]} + {{(AW+2-DW){1'b0}}, r_degree}
                + (AW+2)'(1);

    assign mul_a = (r_state == S_MUL_A) ? r_wa : r_wb;
    assign mul_b = (r_state == S_MUL_A) ? r_node[r_j] : r_node[r_j + DW'(1)];
    assign prod  = (2*VW)'(mul_a) * (2*VW)'(mul_b);
    assign sum   = {1'b0, r_acc} + {1'b0, prod[FRAC_BITS +: VW]};

    always_comb begin
        n_state  = r_state;
        n_degree = r_degree;
        n_d      = r_d;
        n_j      = r_j;
        n_i      = r_i;
        n_u      = r_u;
        n_t0     = r_t0;
        n_t1     = r_t1;
        n_td     = r_td;
        n_te     = r_te;
        n_wa     = r_wa;
        n_wb     = r_wb;
        n_acc    = r_acc;
        n_res    = r_res;
        n_err    = r_err;
        n_out    = r_out;
        n_oerr   = r_oerr;
        n_ovalid = r_ovalid && !m_axis_tready;
        node_we   = 1'b0;
        node_val  = '0;
        node_done = 1'b0;
        ram_raddr = base;
        div_start = 1'b0;
        div_num   = r_u - r_t0;
        div_den   = r_td - r_t0;

        if (psel && penable && pwrite && paddr[2] == REG_DEGREE)
            n_degree = pwdata[DW-1:0];

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid && s_axis_tuser == REQ_EVAL) begin
                    n_u = sat_one({1'b0, s_axis_tdata[39:23]});
                    n_i = s_axis_tdata[45:40];
                    n_j = '0;
                    n_d = DW'(1);
                    if (lim > (AW+2)'(MAX_KNOTS - 1)) begin
                        n_res   = '0;
                        n_err   = 1'b1;
                        n_state = S_OUT;
                    end else begin
                        n_err   = 1'b0;
                        n_state = S_LEAF_RD;
                    end
                end
            end
            // leaves: t[i] first, then one knot a cycle
            S_LEAF_RD: n_state = S_LEAF_T0;
            S_LEAF_T0: begin
                n_t0      = ram_rdata;
                ram_raddr = base + AW'(1);
                n_state   = S_LEAF;
            end
            S_LEAF: begin
                ram_raddr = base + AW'(2);
                node_we   = 1'b1;
                node_val  = (r_u >= r_t0 && r_u <= ram_rdata) ? ONE_FX : '0;
                n_t0      = ram_rdata;
                if (r_j == r_degree) begin
                    n_j = '0;
                    n_d = DW'(1);
                    if (r_degree == '0) begin
                        n_res   = node_val;
                        n_state = S_OUT;
                    end else begin
                        n_state = S_NODE_RD0;
                    end
                end else begin
                    n_j = r_j + DW'(1);
                end
            end
            // node: read t[i+j], t[i+j+1], t[i+j+d], t[i+j+d+1]
            S_NODE_RD0: n_state = S_NODE_RD1;
            S_NODE_RD1: begin
                n_t0      = ram_rdata;
                ram_raddr = base + AW'(1);
                n_state   = S_NODE_RD2;
            end
            S_NODE_RD2: begin
                n_t1      = ram_rdata;
                ram_raddr = base + {{(AW-DW){1'b0}}, r_d};
                n_state   = S_NODE_RD3;
            end
            S_NODE_RD3: begin
                n_td      = ram_rdata;
                ram_raddr = base + {{(AW-DW){1'b0}}, r_d} + AW'(1);
                n_state   = S_NODE_CHK;
            end
            S_NODE_CHK: begin
                n_te = ram_rdata;
                if (r_u < r_t0 || r_u > ram_rdata) begin
                    node_we   = 1'b1;
                    node_val  = '0;
                    node_done = 1'b1;
                end else begin
                    n_state = S_DIV_A;
                end
            end
            S_DIV_A: begin
                if (r_td > r_t0) begin
                    div_start = 1'b1;
                    n_state   = S_WAIT_A;
                end else begin
                    n_wa    = '0;
                    n_state = S_DIV_B;
                end
            end
            S_WAIT_A: begin
                if (div_done) begin
                    n_wa    = div_q;
                    n_state = S_DIV_B;
                end
            end
            S_DIV_B: begin
                div_num = r_te - r_u;
                div_den = r_te - r_t1;
                if (r_te > r_t1) begin
                    div_start = 1'b1;
                    n_state   = S_WAIT_B;
                end else begin
                    n_wb    = '0;
                    n_state = S_MUL_A;
                end
            end
            S_WAIT_B: begin
                div_num = r_te - r_u;
                div_den = r_te - r_t1;
                if (div_done) begin
                    n_wb    = div_q;
                    n_state = S_MUL_A;
                end
            end
            S_MUL_A: begin
                n_acc   = prod[FRAC_BITS +: VW];
                n_state = S_MUL_B;
            end
            S_MUL_B: begin
                node_we   = 1'b1;
                node_val  = sat_one(sum);
                node_done = 1'b1;
            end
            S_OUT: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_out    = r_res;
                    n_oerr   = r_err;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // step to the next node, the next level or the result
        if (node_done) begin
            if (DW'(r_j + r_d) == r_degree) begin
                if (r_d == r_degree) begin
                    n_res   = node_val;
                    n_state = S_OUT;
                end else begin
                    n_d     = r_d + DW'(1);
                    n_j     = '0;
                    n_state = S_NODE_RD0;
                end
            end else begin
                n_j     = r_j + DW'(1);
                n_state = S_NODE_RD0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_degree <= DEGREE_RESET;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_degree <= n_degree;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d    <= n_d;
        r_j    <= n_j;
        r_i    <= n_i;
        r_u    <= n_u;
        r_t0   <= n_t0;
        r_t1   <= n_t1;
        r_td   <= n_td;
        r_te   <= n_te;
        r_wa   <= n_wa;
        r_wb   <= n_wb;
        r_acc  <= n_acc;
        r_res  <= n_res;
        r_err  <= n_err;
        r_out  <= n_out;
        r_oerr <= n_oerr;
        if (node_we) r_node[r_j] <= node_val;
    end
endmodule
`default_nettype wire

// ----- tb/bspline_basis_checker.sv -----
// checker for the b-spline basis evaluator: watches the request, result and apb
// channels, predicts each basis value from its own knot table and compares
// depends on bsb_pkg
`timescale 1ns / 100ps
module bspline_basis_checker
    import bsb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,
    input  logic        s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,
    input  logic        m_axis_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          o_errors,
    output int          o_pending,
    output int          o_index_errors
);
    typedef struct packed {
        logic [VW-1:0] value;
        logic          err;
    } basis_t;

    logic [63:0] knot_mem [MAX_KNOTS];
    int unsigned degree_q;
    basis_t pending_basis[$];
    int n_results;

    assign o_pending = pending_basis.size();

    function automatic logic [63:0] clamp_one(logic [63:0] x);
        return (x > 64'(ONE_FX)) ? 64'(ONE_FX) : x;
    endfunction

    function automatic logic [63:0] knot_weight(logic [63:0] num, logic [63:0] lo,
                                                logic [63:0] hi);
        if (hi <= lo) return 64'd0;
        return clamp_one((num << FRAC_BITS) / (hi - lo));
    endfunction

    function automatic basis_t basis_eval(logic [63:0] u, int unsigned i);
        logic [63:0] node [MAX_DEGREE + 2];
        logic [63:0] t0, t1, td, te, wa, wb;
        basis_t r;
        r.err = 1'b0;
        r.value = '0;
        if (i + degree_q + 1 > MAX_KNOTS - 1) begin
            r.err = 1'b1;
            return r;
        end
        for (int j = 0; j <= degree_q; j++)
            node[j] = (u >= knot_mem[i+j] && u <= knot_mem[i+j+1]) ? 64'(ONE_FX) : 64'd0;
        for (int d = 1; d <= degree_q; d++) begin
            for (int j = 0; j + d <= degree_q; j++) begin
                t0 = knot_mem[i+j];
                t1 = knot_mem[i+j+1];
                td = knot_mem[i+j+d];
                te = knot_mem[i+j+d+1];
                if (u < t0 || u > te) begin
                    node[j] = 0;
                end else begin
                    wa = knot_weight(u - t0, t0, td);
                    wb = knot_weight(te - u, t1, te);
                    node[j] = clamp_one(((wa * node[j]) >> FRAC_BITS)
                                        + ((wb * node[j+1]) >> FRAC_BITS));
                end
            end
        end
        r.value = node[0][VW-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch in result %0d: %s got %0h want %0h", n_results, what, got, want);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        basis_t want;
        if (!i_rst_n) begin
            degree_q <= 3;
            pending_basis.delete();
            o_errors <= 0;
            o_index_errors <= 0;
            n_results <= 0;
            for (int n = 0; n < MAX_KNOTS; n++) knot_mem[n] <= '0;
        end else begin
            if (psel && penable && pwrite && pready && paddr == 3'(REG_DEGREE))
                degree_q <= 32'(pwdata[2:0]);
            if (s_axis_tvalid && s_axis_tready) begin
                if (s_axis_tuser == REQ_WRITE) begin
                    knot_mem[s_axis_tdata[5:0]] <= clamp_one(64'(s_axis_tdata[22:6]));
                end else begin
                    want = basis_eval(clamp_one(64'(s_axis_tdata[39:23])),
                                      32'(s_axis_tdata[45:40]));
                    pending_basis.push_back(want);
                    if (want.err) o_index_errors++;
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                n_results++;
                if (pending_basis.size() == 0) begin
                    $display("unexpected result %0d: value %0h", n_results,
                             m_axis_tdata[VW-1:0]);
                    o_errors++;
                end else begin
                    want = pending_basis.pop_front();
                    if (m_axis_tdata[VW-1:0] !== want.value)
                        report_mismatch("basis_value", 32'(m_axis_tdata[VW-1:0]),
                                        32'(want.value));
                    if (m_axis_tuser !== want.err)
                        report_mismatch("index_error", 32'(m_axis_tuser), 32'(want.err));
                end
            end
        end
    end
endmodule

// ----- tb/tb_top.sv -----
// top of the b-spline basis evaluator testbench: clock, reset, apb and stream
// stimulus, idling and back-pressure, watchdog and verdict
// depends on bsb_pkg, bspline_basis_eval, bspline_basis_checker
`timescale 1ns / 100ps
module tb_top;
    import bsb_pkg::*;

    localparam int WATCHDOG_LIMIT = 40000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;    // knot_index, knot_value, param_u, basis_index
    logic        s_axis_tuser = 1'b0;  // req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;         // basis_value, zero fill
    logic        m_axis_tuser;         // index_error
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int errors, pending, index_errors;
    int send_idle_pct, recv_idle_pct, hold_cycles;
    int n_writes, n_evals, quiet_cycles;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    bspline_basis_eval i_dut (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    bspline_basis_checker i_checker (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
        .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .o_errors(errors), .o_pending(pending), .o_index_errors(index_errors)
    );

    // receiver: random stalls, or a long hold-off when asked
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", quiet_cycles);
            $display("simulation failed");
            $finish;
        end
    end

    task automatic send_request(logic req, logic [5:0] kidx, logic [16:0] kval,
                                logic [16:0] u, logic [5:0] bi);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= req;
        s_axis_tdata <= {2'b00, bi, u, kval, kidx};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (req == REQ_WRITE) n_writes++;
        else n_evals++;
    endtask

    task automatic write_knot(logic [5:0] kidx, logic [16:0] kval);
        send_request(REQ_WRITE, kidx, kval, 17'($urandom), 6'($urandom));
    endtask

    task automatic eval_basis(logic [16:0] u, logic [5:0] bi);
        send_request(REQ_EVAL, 6'($urandom), 17'($urandom), u, bi);
    endtask

    task automatic write_degree(logic [31:0] value);
        @(posedge i_clk);
        s_axis_tvalid <= 1'b0;
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= 3'(REG_DEGREE);
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    // sorted knot run with random spacing and repeats
    task automatic load_sorted_run(int start, int len);
        int v;
        v = $urandom_range(8000);
        for (int n = start; n < start + len && n < MAX_KNOTS; n++) begin
            if ($urandom_range(4) != 0) v += $urandom_range(6000);
            if (v > ONE_FX) v = ONE_FX;
            write_knot(6'(n), 17'(v));
        end
    endtask

    initial begin
        int degs [8] = '{3, 0, 7, 1, 5, 2, 4, 6};
        int items [8] = '{250, 250, 60, 250, 200, 250, 200, 140};
        int done, k, len;
        logic [16:0] u;

        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles = 0;
        n_writes = 0;
        n_evals = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: full table, extremes, repeated knots, degree 3 from reset
        for (int n = 0; n < MAX_KNOTS; n++) write_knot(6'(n), 17'(n * 1040));
        write_knot(6'd63, 17'h1FFFF);
        write_knot(6'd10, 17'd10400);
        write_knot(6'd11, 17'd10400);
        eval_basis(17'd0, 6'd0);
        eval_basis(17'd10400, 6'd8);
        eval_basis(17'd10400, 6'd10);
        eval_basis(17'h10000, 6'd59);
        eval_basis(17'h1FFFF, 6'd59);
        eval_basis(17'd30000, 6'd2);
        eval_basis(17'd5000, 6'd60);
        eval_basis(17'd5000, 6'd63);
        eval_basis(17'h15555, 6'h2A);
        drain();

        for (int p = 0; p < 8; p++) begin
            k = degs[p];
            write_degree(32'(k) | ($urandom & 32'hFFFF_FFF8));
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
                1: begin send_idle_pct = 53; recv_idle_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_idle_pct = 53; end
                default: begin send_idle_pct = 16; recv_idle_pct = 16; end
            endcase
            if (p == 1) hold_cycles = 3000;
            done = 0;
            while (done < items[p]) begin
                case ($urandom_range(15))
                    0, 1: begin
                        len = $urandom_range(4, 16);
                        load_sorted_run($urandom_range(MAX_KNOTS - 1), len);
                        done += len;
                    end
                    2: begin
                        write_knot(6'($urandom), 17'($urandom));
                        done++;
                    end
                    3: begin
                        eval_basis(17'($urandom), 6'($urandom));
                        done++;
                    end
                    default: begin
                        u = ($urandom_range(9) == 0) ? 17'($urandom_range(ONE_FX, 17'h1FFFF))
                                                     : 17'($urandom_range(ONE_FX));
                        eval_basis(u, 6'($urandom_range(MAX_KNOTS - 2 - k)));
                        done++;
                    end
                endcase
            end
            drain();
        end

        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (2500) @(posedge i_clk);
        $display("covered %0d knot writes and %0d evaluations (%0d out of range)",
                 n_writes, n_evals, index_errors);
        $display("degrees 0 to 7, idle and stall mixes, one long result hold-off");
        if (errors == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

// ----- bspline_basis_eval.f -----
rtl/bsb_pkg.sv
rtl/bsb_ram.sv
rtl/bsb_div.sv
rtl/bspline_basis_eval.sv
tb/bspline_basis_checker.sv
tb/tb_top.sv
